// ===== rtl/dft2d_pkg.sv =====
// ============================================================================
// dft2d_pkg
// Shared types, constants and saturation helpers for the 2D DFT matrix core.
// ============================================================================
`default_nettype none

package dft2d_pkg;

    localparam int IDX_W     = 6;   // row / column index width
    localparam int VAL_W     = 16;  // sample and coefficient part width
    localparam int T_W       = 24;  // first-pass element part width
    localparam int Y_W       = 30;  // result element part width
    localparam int FRAC_BITS = 14;
    localparam int ACC_W     = 52;  // exact sum of up to 512 full products
    localparam int PROD_W    = VAL_W + T_W;

    localparam logic signed [ACC_W-1:0] T_HI = ACC_W'((64'sd1 <<< (T_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] T_LO = -T_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Y_HI = ACC_W'((64'sd1 <<< (Y_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] Y_LO = -Y_HI - ACC_W'(1);

    typedef enum logic [1:0] {
        OP_WR_DFT = 2'd0,
        OP_WR_IMG = 2'd1,
        OP_RUN    = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic {
        KIND_ACK  = 1'b0,
        KIND_DATA = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN1,
        ST_WAIT1,
        ST_RUN2,
        ST_WAIT2,
        ST_ACK
    } seq_state_t;

    // partial sum for one output element, moving down the cell chain
    typedef struct packed {
        logic                    vld;
        logic [IDX_W-1:0]        i;
        logic [IDX_W-1:0]        j;
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
    } chain_t;

    // host load of one F entry or one image sample
    typedef struct packed {
        logic                    vld;
        logic                    img;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] re;
        logic signed [VAL_W-1:0] im;
    } host_wr_t;

    // first-pass element written back into the cells
    typedef struct packed {
        logic                  vld;
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        logic signed [T_W-1:0] re;
        logic signed [T_W-1:0] im;
    } trow_wr_t;

    function automatic logic signed [T_W-1:0] sat_t(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] sh;
        sh = x >>> FRAC_BITS;
        if (sh > T_HI)
            return T_HI[T_W-1:0];
        else if (sh < T_LO)
            return T_LO[T_W-1:0];
        else
            return sh[T_W-1:0];
    endfunction

    function automatic logic signed [Y_W-1:0] sat_y(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] sh;
        sh = x >>> FRAC_BITS;
        if (sh > Y_HI)
            return Y_HI[Y_W-1:0];
        else if (sh < Y_LO)
            return Y_LO[Y_W-1:0];
        else
            return sh[Y_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dft2d_cell.sv =====
// ============================================================================
// dft2d_cell
// One multiply-accumulate cell of the chain. Cell m holds column m of the
// left operands and row m of the right operands and adds term m to each
// partial sum that passes through it.
// ============================================================================
`default_nettype none

module dft2d_cell
    import dft2d_pkg::*;
#(
    parameter int N       = 64,
    parameter int CELL_ID = 0
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     pass,
    input  wire host_wr_t hw,
    input  wire trow_wr_t tw,
    input  wire chain_t   c_in,
    output chain_t        c_out
);

    localparam int AW = $clog2(N);
    localparam logic [IDX_W-1:0] ME = IDX_W'(CELL_ID);

    logic [2*VAL_W-1:0] fcol_mem [N];   // F[i][m]
    logic [2*VAL_W-1:0] frow_mem [N];   // F[m][j]
    logic [2*VAL_W-1:0] xcol_mem [N];   // X[i][m]
    logic [2*T_W-1:0]   trow_mem [N];   // T[m][j]

    logic [2*VAL_W-1:0] fc_reg, fr_reg, xc_reg;
    logic [2*T_W-1:0]   tr_reg;
    chain_t             s1_reg, s2_reg, out_reg;

    logic signed [VAL_W-1:0]  a_re, a_im;
    logic signed [T_W-1:0]    b_re, b_im;
    logic signed [PROD_W-1:0] rr_reg, ii_reg, ri_reg, ir_reg;

    always_ff @(posedge clk)
    begin
        if (hw.vld && !hw.img && hw.col == ME)
            fcol_mem[hw.row[AW-1:0]] <= {hw.im, hw.re};
        if (hw.vld && !hw.img && hw.row == ME)
            frow_mem[hw.col[AW-1:0]] <= {hw.im, hw.re};
        if (hw.vld && hw.img && hw.col == ME)
            xcol_mem[hw.row[AW-1:0]] <= {hw.im, hw.re};
        if (tw.vld && tw.row == ME)
            trow_mem[tw.col[AW-1:0]] <= {tw.im, tw.re};
        fc_reg <= fcol_mem[c_in.i[AW-1:0]];
        xc_reg <= xcol_mem[c_in.i[AW-1:0]];
        fr_reg <= frow_mem[c_in.j[AW-1:0]];
        tr_reg <= trow_mem[c_in.j[AW-1:0]];
    end

    // pass one: X * F, pass two: F * T
    always_comb
    begin
        if (pass)
        begin
            a_re = fc_reg[VAL_W-1:0];
            a_im = fc_reg[2*VAL_W-1:VAL_W];
            b_re = tr_reg[T_W-1:0];
            b_im = tr_reg[2*T_W-1:T_W];
        end
        else
        begin
            a_re = xc_reg[VAL_W-1:0];
            a_im = xc_reg[2*VAL_W-1:VAL_W];
            b_re = T_W'($signed(fr_reg[VAL_W-1:0]));
            b_im = T_W'($signed(fr_reg[2*VAL_W-1:VAL_W]));
        end
    end

    always_ff @(posedge clk)
    begin
        rr_reg <= PROD_W'(a_re) * PROD_W'(b_re);
        ii_reg <= PROD_W'(a_im) * PROD_W'(b_im);
        ri_reg <= PROD_W'(a_re) * PROD_W'(b_im);
        ir_reg <= PROD_W'(a_im) * PROD_W'(b_re);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            out_reg <= '0;
        end
        else
        begin
            s1_reg      <= c_in;
            s2_reg      <= s1_reg;
            out_reg.vld <= s2_reg.vld;
            out_reg.i   <= s2_reg.i;
            out_reg.j   <= s2_reg.j;
            out_reg.re  <= s2_reg.re + ACC_W'(rr_reg) - ACC_W'(ii_reg);
            out_reg.im  <= s2_reg.im + ACC_W'(ri_reg) + ACC_W'(ir_reg);
        end
    end

    assign c_out = out_reg;

endmodule

`default_nettype wire

// ===== rtl/dft_2d_by_matrix_product_core.sv =====
// ============================================================================
// dft_2d_by_matrix_product_core
// Square 2D complex DFT, Y = F * X * F, on a chain of multiply-accumulate cells.
// ============================================================================
// Usage: every command arrives as one beat on the s_ channel. Op 0 loads one
// F entry (Q1.14), op 1 one image sample; both give no result and may follow
// each other back to back. Op 3 reads Y[row][col]: the read beat sets a
// pending flag, then the registered store data loads the output register and
// m_tvalid rises (m_tuser = 1). Op 2 runs the transform and returns one beat
// with m_tuser = 0 and zero data. With N = TILES_PER_SIDE * TILE_EDGE (at
// most 64), each pass streams N*N partial sums through N cells of three
// stages each, and the cell chain depth sets the drain time before the next
// pass or the run acknowledge.
// s_tready is low while a run is in progress, a read is pending or a result
// beat is held. When the receiver stalls, the result beat holds in the output
// register and no new command is taken until it leaves. Reset clears the
// sequencer and the output register; the stores come up undefined and must
// be loaded before they are used.
// ============================================================================
`default_nettype none

module dft_2d_by_matrix_product_core
    import dft2d_pkg::*;
#(
    parameter int TILES_PER_SIDE = 2,
    parameter int TILE_EDGE      = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // op[1:0], row[7:2], col[13:8],
                                        // value_real[29:14], value_imag[45:30]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // out_real[29:0], out_imag[59:30]
    output logic             m_tuser    // kind
);

    localparam int N   = TILES_PER_SIDE * TILE_EDGE;
    localparam int YAW = $clog2(N * N);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(N - 1);

    seq_state_t state_reg, state_next;

    logic             s_acc;
    op_t              op;
    logic [IDX_W-1:0] row, col;
    logic             in_range;

    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next;
    logic             issue, pass, ack_load, issue_last, tail_last;

    host_wr_t hw;
    trow_wr_t tw;
    chain_t   link [N+1];
    chain_t   tail;

    logic [2*Y_W-1:0] y_mem [N*N];
    logic [YAW-1:0]   y_waddr, y_raddr;
    logic [2*Y_W-1:0] y_rdata_reg;
    logic             rd_pend_reg, rd_in_reg;

    logic              m_tvalid_reg;
    logic              m_kind_reg;
    logic [2*Y_W-1:0]  m_data_reg;

    assign op       = op_t'(s_tdata[1:0]);
    assign row      = s_tdata[7:2];
    assign col      = s_tdata[13:8];
    assign in_range = (32'(row) < N) && (32'(col) < N);

    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid_reg && !rd_pend_reg;
    assign s_acc    = s_tvalid && s_tready;

    // ---------------- sequencer ----------------
    assign tail       = link[N];
    assign issue_last = (i_reg == LAST) && (j_reg == LAST);
    assign tail_last  = tail.vld && (tail.i == LAST) && (tail.j == LAST);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_acc && op == OP_RUN) state_next = ST_RUN1;
            ST_RUN1:  if (issue_last)            state_next = ST_WAIT1;
            ST_WAIT1: if (tail_last)             state_next = ST_RUN2;
            ST_RUN2:  if (issue_last)            state_next = ST_WAIT2;
            ST_WAIT2: if (tail_last)             state_next = ST_ACK;
            ST_ACK:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        issue    = 1'b0;
        pass     = 1'b0;
        ack_load = 1'b0;
        case (state_reg)
            ST_RUN1:  issue = 1'b1;
            ST_RUN2:
            begin
                issue = 1'b1;
                pass  = 1'b1;
            end
            ST_WAIT2: pass = 1'b1;
            ST_ACK:   ack_load = 1'b1;
            default:  ;
        endcase
    end

    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        if (!issue)
        begin
            i_next = '0;
            j_next = '0;
        end
        else if (j_reg == LAST)
        begin
            j_next = '0;
            i_next = i_reg + IDX_W'(1);
        end
        else
            j_next = j_reg + IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    // ---------------- cell chain ----------------
    always_comb
    begin
        link[0]     = '0;
        link[0].vld = issue;
        link[0].i   = i_reg;
        link[0].j   = j_reg;
    end

    always_comb
    begin
        hw.vld = s_acc && in_range && (op == OP_WR_DFT || op == OP_WR_IMG);
        hw.img = (op == OP_WR_IMG);
        hw.row = row;
        hw.col = col;
        hw.re  = s_tdata[29:14];
        hw.im  = s_tdata[45:30];
    end

    always_comb
    begin
        tw.vld = tail.vld && !pass;
        tw.row = tail.i;
        tw.col = tail.j;
        tw.re  = sat_t(tail.re);
        tw.im  = sat_t(tail.im);
    end

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        dft2d_cell #(
            .N       (N),
            .CELL_ID (k)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .pass  (pass),
            .hw    (hw),
            .tw    (tw),
            .c_in  (link[k]),
            .c_out (link[k+1])
        );
    end

    // ---------------- result store ----------------
    assign y_waddr = YAW'(32'(tail.i) * N + 32'(tail.j));
    assign y_raddr = in_range ? YAW'(32'(row) * N + 32'(col)) : '0;

    always_ff @(posedge clk)
    begin
        if (tail.vld && pass)
            y_mem[y_waddr] <= {sat_y(tail.im), sat_y(tail.re)};
        y_rdata_reg <= y_mem[y_raddr];
        rd_in_reg   <= in_range;
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_kind_reg   <= KIND_ACK;
            m_data_reg   <= '0;
        end
        else
        begin
            rd_pend_reg <= s_acc && (op == OP_READ);
            if (ack_load)
            begin
                m_tvalid_reg <= 1'b1;
                m_kind_reg   <= KIND_ACK;
                m_data_reg   <= '0;
            end
            else if (rd_pend_reg)
            begin
                m_tvalid_reg <= 1'b1;
                m_kind_reg   <= KIND_DATA;
                m_data_reg   <= rd_in_reg ? y_rdata_reg : '0;
            end
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {4'b0, m_data_reg};

    // ---------------- assertions ----------------
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("command accepted during a run");

    a_chain_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        tail.vld |-> (state_reg == ST_RUN1 || state_reg == ST_WAIT1 ||
                      state_reg == ST_RUN2 || state_reg == ST_WAIT2))
        else $error("partial sum left the chain outside a run");

    a_ack_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        ack_load |-> $past(state_reg) == ST_WAIT2)
        else $error("acknowledge without a finished second pass");

    a_read_beat: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |=> m_tvalid_reg && m_kind_reg == KIND_DATA)
        else $error("read data beat missing");

endmodule

`default_nettype wire
